/* design/psd_pkg.sv */
// Package for the pairwise squared distance block: word types, sizes and codes.
// No dependencies; every design file refers to it by scoped names.
`default_nettype none
package psd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int POS_W   = 16;
    localparam int OIDX_W  = 6;
    localparam int DIST_W  = 41;
    localparam int SIZE_W  = 13;
    localparam int NUM_W   = POS_W + 12;
    localparam int DCNT_W  = $clog2(NUM_W);
    localparam int PROD_W  = 2 * NUM_W;
    localparam int CFG_A_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_A_W-1:0] REG_NORMALIZE = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_HEIGHT    = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_WIDTH     = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] row_pos;
        logic [POS_W-1:0] col_pos;
        logic             last_point;
    } in_word_t;

    typedef struct packed {
        logic [OIDX_W-1:0] row_index;
        logic [OIDX_W-1:0] col_index;
        logic [DIST_W-1:0] distance;
        logic              last_of_run;
    } out_word_t;

    // One stored point handed from the front to the back
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [IDX_W-1:0] idx;
    } cmd_t;

endpackage
`default_nettype wire

/* design/pairwise_sq_distance_matrix.sv */
// Pairwise squared distance matrix: one point word in, one result word per
// earlier point of the set (lower triangle), earlier index j ascending. Each pair reads
// the point store once and passes the shared squarer twice; with normalizing on,
// the radix-2 dividers set the pace. Each point also takes a queue pop and a
// store write. A 2-word queue lets new points be taken while results are
// worked out.
// Depends on psd_pkg, psd_front and psd_back.
`default_nettype none
module pairwise_sq_distance_matrix (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [psd_pkg::CFG_A_W-1:0] cfg_index,
    input  wire logic [psd_pkg::SIZE_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire psd_pkg::in_word_t           in_word,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output psd_pkg::out_word_t               out_word
);

    logic          q_valid, q_pop;
    psd_pkg::cmd_t q_cmd;

    psd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    psd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
`default_nettype wire

/* design/psd_front.sv */
// Front end: accepts input words, keeps the point count, queues kept points.
// Depends on psd_pkg.
`default_nettype none
module psd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire psd_pkg::in_word_t in_word,
    output logic                   q_valid,
    output psd_pkg::cmd_t          q_cmd,
    input  wire logic              q_pop
);

    logic [psd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    psd_pkg::cmd_t             slot_reg [2];
    logic                      wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                fill_reg, fill_next;
    logic                      accept, keep, push;

    assign in_stall = (fill_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign keep     = (cnt_reg < psd_pkg::CNT_W'(psd_pkg::MAX_POINTS));
    assign push     = accept && keep;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];

    // Advance the count; a last word closes the set
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (in_word.last_point)
                cnt_next = '0;
            else if (keep)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !q_pop)
            fill_next = fill_reg + 2'd1;
        else if (!push && q_pop)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            fill_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].row <= in_word.row_pos;
            slot_reg[wr_ptr_reg].col <= in_word.col_pos;
            slot_reg[wr_ptr_reg].idx <= psd_pkg::IDX_W'(cnt_reg);
        end
    end

endmodule
`default_nettype wire

/* design/psd_back.sv */
// Back end: point store, row and column dividers, shared squarer, result register, config.
// Depends on psd_pkg.
`default_nettype none
module psd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [psd_pkg::CFG_A_W-1:0]   cfg_index,
    input  wire logic [psd_pkg::SIZE_W-1:0]    cfg_data,
    input  wire logic                          q_valid,
    input  wire psd_pkg::cmd_t                 q_cmd,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output psd_pkg::out_word_t                 out_word
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_LD    = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_SQR   = 8'b0001_0000,
        S_SQC   = 8'b0010_0000,
        S_PUT   = 8'b0100_0000,
        S_STORE = 8'b1000_0000
    } state_t;

    localparam int W = 2 * psd_pkg::POS_W;

    state_t                        state_reg, state_next;
    logic                          norm_reg;
    logic [psd_pkg::SIZE_W-1:0]    height_reg, width_reg, div_r, div_c;
    logic [W-1:0]                  mem [psd_pkg::MAX_POINTS];
    logic [W-1:0]                  rd_reg;
    psd_pkg::cmd_t                 cmd_reg;
    logic [psd_pkg::IDX_W-1:0]     j_reg;
    logic [psd_pkg::POS_W-1:0]     dh_reg, dw_reg, dh, dw;
    logic [psd_pkg::NUM_W-1:0]     nr_reg, nc_reg, qr_reg, qc_reg;
    logic [psd_pkg::SIZE_W-1:0]    rr_reg, rc_reg;
    logic [psd_pkg::SIZE_W:0]      tr, tc;
    logic [psd_pkg::DCNT_W-1:0]    dcnt_reg;
    logic [psd_pkg::NUM_W-1:0]     sq_op;
    logic [psd_pkg::PROD_W-1:0]    prod;
    logic [psd_pkg::DIST_W-1:0]    term, acc_reg;
    logic                          out_valid_reg, take, load, last_pair;
    psd_pkg::out_word_t            out_word_reg;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign take      = out_valid_reg && !out_stall;
    assign load      = (state_reg == S_PUT) && (!out_valid_reg || !out_stall);
    assign last_pair = (j_reg == cmd_reg.idx - 1'b1);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    // Zero frame size acts as one
    assign div_r = (height_reg == '0) ? psd_pkg::SIZE_W'(1) : height_reg;
    assign div_c = (width_reg == '0) ? psd_pkg::SIZE_W'(1) : width_reg;

    // Magnitudes of the differences against the stored point
    assign dh = (cmd_reg.row >= rd_reg[W-1:psd_pkg::POS_W])
              ? cmd_reg.row - rd_reg[W-1:psd_pkg::POS_W]
              : rd_reg[W-1:psd_pkg::POS_W] - cmd_reg.row;
    assign dw = (cmd_reg.col >= rd_reg[psd_pkg::POS_W-1:0])
              ? cmd_reg.col - rd_reg[psd_pkg::POS_W-1:0]
              : rd_reg[psd_pkg::POS_W-1:0] - cmd_reg.col;

    // Restoring divider trial subtraction, one quotient bit a cycle
    assign tr = {rr_reg, nr_reg[psd_pkg::NUM_W-1]};
    assign tc = {rc_reg, nc_reg[psd_pkg::NUM_W-1]};

    // Shared squarer: row term, then column term
    always_comb
    begin
        if (state_reg == S_SQR)
            sq_op = norm_reg ? qr_reg : psd_pkg::NUM_W'(dh_reg);
        else
            sq_op = norm_reg ? qc_reg : psd_pkg::NUM_W'(dw_reg);
        prod = sq_op * sq_op;
        term = norm_reg ? psd_pkg::DIST_W'(prod >> 16) : psd_pkg::DIST_W'(prod << 8);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid)
                         state_next = (q_cmd.idx == '0) ? S_STORE : S_RD;
            S_RD:    state_next = S_LD;
            S_LD:    state_next = norm_reg ? S_DIV : S_SQR;
            S_DIV:   if (dcnt_reg == psd_pkg::DCNT_W'(psd_pkg::NUM_W - 1))
                         state_next = S_SQR;
            S_SQR:   state_next = S_SQC;
            S_SQC:   state_next = S_PUT;
            S_PUT:   if (load)
                         state_next = last_pair ? S_STORE : S_RD;
            S_STORE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            norm_reg      <= 1'b0;
            height_reg    <= psd_pkg::SIZE_W'(1);
            width_reg     <= psd_pkg::SIZE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (take)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == psd_pkg::REG_NORMALIZE)
                    norm_reg <= cfg_data[0];
                else if (cfg_index == psd_pkg::REG_HEIGHT)
                    height_reg <= cfg_data;
                else if (cfg_index == psd_pkg::REG_WIDTH)
                    width_reg <= cfg_data;
            end
        end
    end

    // Point store: write at the end of an item, registered read per pair
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE)
            mem[cmd_reg.idx] <= {cmd_reg.row, cmd_reg.col};
        if (state_reg == S_RD)
            rd_reg <= mem[j_reg];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            j_reg   <= '0;
        end
        if (state_reg == S_LD)
        begin
            dh_reg   <= dh;
            dw_reg   <= dw;
            nr_reg   <= {dh, 12'b0};
            nc_reg   <= {dw, 12'b0};
            rr_reg   <= '0;
            rc_reg   <= '0;
            qr_reg   <= '0;
            qc_reg   <= '0;
            dcnt_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            nr_reg   <= nr_reg << 1;
            nc_reg   <= nc_reg << 1;
            dcnt_reg <= dcnt_reg + 1'b1;
            if (tr >= {1'b0, div_r})
            begin
                rr_reg <= psd_pkg::SIZE_W'(tr - {1'b0, div_r});
                qr_reg <= {qr_reg[psd_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rr_reg <= tr[psd_pkg::SIZE_W-1:0];
                qr_reg <= {qr_reg[psd_pkg::NUM_W-2:0], 1'b0};
            end
            if (tc >= {1'b0, div_c})
            begin
                rc_reg <= psd_pkg::SIZE_W'(tc - {1'b0, div_c});
                qc_reg <= {qc_reg[psd_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rc_reg <= tc[psd_pkg::SIZE_W-1:0];
                qc_reg <= {qc_reg[psd_pkg::NUM_W-2:0], 1'b0};
            end
        end
        if (state_reg == S_SQR)
            acc_reg <= term;
        if (state_reg == S_SQC)
            acc_reg <= acc_reg + term;
        if (load)
        begin
            out_word_reg.row_index   <= psd_pkg::OIDX_W'(cmd_reg.idx);
            out_word_reg.col_index   <= psd_pkg::OIDX_W'(j_reg);
            out_word_reg.distance    <= acc_reg;
            out_word_reg.last_of_run <= last_pair;
            j_reg                    <= j_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

/* design/psd_checker.sv */
// Port checker for the pairwise squared distance block, bound to the top level.
// Depends on psd_pkg.
`default_nettype none
module psd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire psd_pkg::out_word_t out_word
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled result word changed");

    // Earlier point index stays below the newer one
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.col_index < out_word.row_index)
        else $error("pair indexes out of order");

    // Close a run on the pair next to the diagonal only
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.last_of_run ==
            (psd_pkg::OIDX_W'(out_word.col_index + 1'b1) == out_word.row_index)))
        else $error("last_of_run mismatch");

    // A point zero never yields a result
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.row_index != '0)
        else $error("result for first point");

endmodule

bind pairwise_sq_distance_matrix psd_checker u_psd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
`default_nettype wire
